@@ rtl/core/mdlp_pkg.sv @@
package mdlp_pkg;

    localparam int unsigned FRAME_DEPTH = 6;
    localparam int unsigned FILL_W      = 3;

    localparam logic [7:0] CMD_SOFT_RESET = 8'h01;
    localparam logic [7:0] CMD_SET_COLOR  = 8'h02;
    localparam logic [7:0] CMD_FADE       = 8'h03;
    localparam logic [7:0] ADDR_BROADCAST = 8'h00;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_FADE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [FILL_W-1:0] FILL_SET_DONE  = 3'd4;
    localparam logic [FILL_W-1:0] FILL_FADE_DONE = 3'd6;
    localparam logic [FILL_W-1:0] FILL_FULL      = 3'd6;

    typedef struct packed {
        logic       ninth_bit;
        logic [7:0] data_byte;
    } t_char;

    typedef struct packed {
        logic [1:0] cmd_kind;
        logic [7:0] speed_high;
        logic [7:0] speed_low;
        logic [7:0] level_ch0;
        logic [7:0] level_ch1;
        logic [7:0] level_ch2;
    } t_cmd;

    // one parsed request handed from the parser to the result register
    typedef struct packed {
        logic emit;
        t_cmd cmd;
    } t_step;

endpackage

@@ rtl/core/mdlp_parser.sv @@
module mdlp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  mdlp_pkg::t_char i_char,
    input  logic [7:0]    i_node_address,
    output mdlp_pkg::t_step o_step
);
    import mdlp_pkg::*;

    logic                 r_listening;
    logic                 n_listening;
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [7:0]           r_frame [FRAME_DEPTH];
    logic [7:0]           w_view  [FRAME_DEPTH];
    logic                 w_store;
    logic [FILL_W-1:0]    w_fill_inc;

    assign w_store    = !i_char.ninth_bit && !r_listening && (r_fill < FILL_FULL);
    assign w_fill_inc = r_fill + {{(FILL_W-1){1'b0}}, 1'b1};

    // frame as it looks after this byte is stored
    always_comb begin
        for (int k = 0; k < FRAME_DEPTH; k++) begin
            w_view[k] = (w_store && r_fill == FILL_W'(k)) ? i_char.data_byte : r_frame[k];
        end
    end

    always_comb begin
        n_listening   = r_listening;
        n_fill        = r_fill;
        o_step        = '0;
        o_step.cmd.cmd_kind = KIND_SET;
        if (i_char.ninth_bit) begin
            if (i_char.data_byte == ADDR_BROADCAST || i_char.data_byte == i_node_address) begin
                n_listening = 1'b0;
                n_fill      = '0;
            end else begin
                n_listening = 1'b1;
            end
        end else if (w_store) begin
            n_fill = w_fill_inc;
            if (w_view[0] == CMD_SOFT_RESET) begin
                n_listening         = 1'b1;
                o_step.emit         = 1'b1;
                o_step.cmd.cmd_kind = KIND_RESET;
            end else if (w_view[0] == CMD_SET_COLOR && w_fill_inc == FILL_SET_DONE) begin
                n_listening          = 1'b1;
                o_step.emit          = 1'b1;
                o_step.cmd.cmd_kind  = KIND_SET;
                o_step.cmd.level_ch0 = w_view[1];
                o_step.cmd.level_ch1 = w_view[2];
                o_step.cmd.level_ch2 = w_view[3];
            end else if (w_view[0] == CMD_FADE && w_fill_inc == FILL_FADE_DONE) begin
                n_listening           = 1'b1;
                o_step.emit           = 1'b1;
                o_step.cmd.cmd_kind   = KIND_FADE;
                o_step.cmd.speed_high = w_view[1];
                o_step.cmd.speed_low  = w_view[2];
                o_step.cmd.level_ch0  = w_view[3];
                o_step.cmd.level_ch1  = w_view[4];
                o_step.cmd.level_ch2  = w_view[5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listening <= 1'b1;
            r_fill      <= '0;
        end else if (i_advance) begin
            r_listening <= n_listening;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_store) begin
            r_frame[r_fill] <= i_char.data_byte;
        end
    end

endmodule

@@ rtl/core/mdlp_out_reg.sv @@
module mdlp_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  mdlp_pkg::t_step i_step,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output mdlp_pkg::t_cmd o_out_data
);
    import mdlp_pkg::*;

    logic r_valid;
    t_cmd r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_step.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_step.emit) begin
            r_data <= i_step.cmd;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ rtl/core/multidrop_led_command_parser.sv @@
// Multidrop LED command parser.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one 9-bit bus
// character per request: the address flag and the payload byte. Output
// channel (o_out_valid / i_out_ready / o_out_data) gives one decoded LED
// command per complete soft-reset, set-color or fade frame.
// i_cfg_we / i_cfg_data write the node address; write only while idle.
// Path: a character sits in the input register, is parsed, and the command
// lands in the output register, which drives o_out_valid.
// Throughput: one character per cycle, set by the single parse step between
// the input register and the output register.
// A stalled output stops the parse step only while a result is waiting; the
// input register then holds one more character and o_in_ready drops.
// Reset (synchronous, active low) empties both registers, sets the node
// address to 1, puts the node in listening mode and clears the fill count.
module multidrop_led_command_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mdlp_pkg::t_char i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mdlp_pkg::t_cmd  o_out_data,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data
);
    import mdlp_pkg::*;

    logic       r_in_valid;
    t_char      r_in;
    logic [7:0] r_node_address;
    logic       w_advance;
    t_step      w_step;

    assign w_advance  = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_node_address <= 8'd1;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                r_node_address <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    mdlp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_char         (r_in),
        .i_node_address (r_node_address),
        .o_step         (w_step)
    );

    mdlp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_step      (w_step),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cmd_kind == KIND_SET ||
                         o_out_data.cmd_kind == KIND_FADE ||
                         o_out_data.cmd_kind == KIND_RESET))
        else $error("illegal command kind in result");

    a_speed_only_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cmd_kind != KIND_FADE) |->
            (o_out_data.speed_high == 8'd0 && o_out_data.speed_low == 8'd0))
        else $error("speed bytes set on non-fade command");

    a_reset_levels_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cmd_kind == KIND_RESET) |->
            (o_out_data.level_ch0 == 8'd0 && o_out_data.level_ch1 == 8'd0 &&
             o_out_data.level_ch2 == 8'd0))
        else $error("soft reset carries levels");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("pending character lost from input register");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mdlp_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned PHASE_CHARS  = 115;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_char      i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_cmd       o_out_data;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    // parser state mirrored by the predictor
    logic [7:0]        node_addr;
    logic              listening;
    logic [FILL_W-1:0] fill;
    logic [7:0]        frame [FRAME_DEPTH];

    t_cmd        expected_cmds [$];
    t_cmd        oldest_cmd;
    int unsigned chars_parsed;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    multidrop_led_command_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare every delivered command with the oldest predicted one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cmds.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected command: expected none actual %p", o_out_data);
            end else begin
                oldest_cmd = expected_cmds.pop_front();
                if (o_out_data.cmd_kind   !== oldest_cmd.cmd_kind   ||
                    o_out_data.speed_high !== oldest_cmd.speed_high ||
                    o_out_data.speed_low  !== oldest_cmd.speed_low  ||
                    o_out_data.level_ch0  !== oldest_cmd.level_ch0  ||
                    o_out_data.level_ch1  !== oldest_cmd.level_ch1  ||
                    o_out_data.level_ch2  !== oldest_cmd.level_ch2) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("command mismatch: expected %p actual %p",
                                 oldest_cmd, o_out_data);
                end
            end
        end
    end

    task automatic parse_char(input t_char c);
        t_cmd r;
        r = '0;
        if (c.ninth_bit) begin
            if (c.data_byte == ADDR_BROADCAST || c.data_byte == node_addr) begin
                listening = 1'b0;
                fill      = '0;
            end else begin
                listening = 1'b1;
            end
            chars_parsed++;
        end else if (!listening && fill < FRAME_DEPTH) begin
            frame[fill] = c.data_byte;
            fill        = fill + 1'b1;
            chars_parsed++;
            if (frame[0] == CMD_SOFT_RESET) begin
                r.cmd_kind = KIND_RESET;
                listening  = 1'b1;
                expected_cmds.push_back(r);
            end else if (frame[0] == CMD_SET_COLOR && fill == FILL_SET_DONE) begin
                r.cmd_kind  = KIND_SET;
                r.level_ch0 = frame[1];
                r.level_ch1 = frame[2];
                r.level_ch2 = frame[3];
                listening   = 1'b1;
                expected_cmds.push_back(r);
            end else if (frame[0] == CMD_FADE && fill == FILL_FADE_DONE) begin
                r.cmd_kind   = KIND_FADE;
                r.speed_high = frame[1];
                r.speed_low  = frame[2];
                r.level_ch0  = frame[3];
                r.level_ch1  = frame[4];
                r.level_ch2  = frame[5];
                listening    = 1'b1;
                expected_cmds.push_back(r);
            end
        end
    endtask

    // entered and left at a falling edge; valid stays high into the next call
    task automatic send_char(input logic is_addr, input logic [7:0] b);
        t_char c;
        c.ninth_bit = is_addr;
        c.data_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        parse_char(c);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(negedge i_clk);
        // a frame that gives no command may still be in the pipe
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_node_address(input logic [7:0] a);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        node_addr  = a;
    endtask

    function automatic logic [7:0] select_addr();
        return $urandom_range(1) ? ADDR_BROADCAST : node_addr;
    endfunction

    task automatic send_random_frame();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 72) begin
            send_char(1'b1, select_addr());
            case ($urandom_range(2))
                0: send_char(1'b0, CMD_SOFT_RESET);
                1: begin
                    send_char(1'b0, CMD_SET_COLOR);
                    repeat (3) send_char(1'b0, 8'($urandom_range(255)));
                end
                default: begin
                    send_char(1'b0, CMD_FADE);
                    repeat (5) send_char(1'b0, 8'($urandom_range(255)));
                end
            endcase
            if ($urandom_range(7) == 0)
                send_char(1'b0, 8'($urandom_range(255)));
        end else if (pick < 84) begin
            // set-color or fade frame with up to three data bytes; a fade is always cut short
            send_char(1'b1, select_addr());
            send_char(1'b0, $urandom_range(1) ? CMD_SET_COLOR : CMD_FADE);
            repeat ($urandom_range(3)) send_char(1'b0, 8'($urandom_range(255)));
        end else if (pick < 92) begin
            send_char(1'b1, select_addr());
            do
                b = 8'($urandom_range(255));
            while (b >= CMD_SOFT_RESET && b <= CMD_FADE);
            send_char(1'b0, b);
            repeat ($urandom_range(8)) send_char(1'b0, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4))
                send_char(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_frames();
        send_char(1'b1, ADDR_BROADCAST);
        send_char(1'b0, CMD_SOFT_RESET);
        send_char(1'b0, CMD_SET_COLOR);        // ignored, back to listening
        send_char(1'b1, node_addr);
        send_char(1'b0, CMD_SET_COLOR);
        send_char(1'b0, 8'h00);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'h80);
        send_char(1'b1, 8'hFF);                // other node
        send_char(1'b0, CMD_SOFT_RESET);
        send_char(1'b1, ADDR_BROADCAST);
        send_char(1'b0, CMD_FADE);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'h00);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'h00);
        send_char(1'b0, 8'hFF);
        send_char(1'b1, ADDR_BROADCAST);       // unknown command fills up
        send_char(1'b0, 8'hFF);
        repeat (6) send_char(1'b0, 8'h01);
        send_char(1'b1, node_addr);
        send_char(1'b0, CMD_FADE);
        send_char(1'b1, ADDR_BROADCAST);       // restart mid frame
        send_char(1'b0, CMD_SOFT_RESET);
    endtask

    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input logic [7:0] addr);
        int unsigned target;
        write_node_address(addr);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = chars_parsed + PHASE_CHARS;
        while (chars_parsed < target)
            send_random_frame();
    endtask

    int unsigned drain_cycles;

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 8'd0;
        node_addr     = 8'd1;
        listening     = 1'b1;
        fill          = '0;
        chars_parsed  = 0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 71;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_random_traffic(13, 71, 8'hFF);
        test_random_traffic(71, 13, 8'($urandom_range(2, 254)));
        test_random_traffic(0, 0, 8'h01);

        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_cmds.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_cmds.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
